/* src/vospi_segment_reassembler_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the segment reassembler.
// ---------------------------------------------------------------------------
`ifndef VOSPI_SEGMENT_REASSEMBLER_ASSERT_SVH
`define VOSPI_SEGMENT_REASSEMBLER_ASSERT_SVH

// same-cycle implication
`define VSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define VSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/vsr_pkg.sv */
// ---------------------------------------------------------------------------
// Segment reassembler package
// Geometry constants, codes and types shared by the reassembler files.
// ---------------------------------------------------------------------------
package vsr_pkg;

  localparam int WordsPerPacket    = 82;
  localparam int PacketsPerSegment = 60;
  localparam int SegmentCount      = 4;
  localparam int SegmentIdPacket   = 20;

  localparam int PixCols    = WordsPerPacket - 2;
  localparam int ImgRows    = SegmentCount * PacketsPerSegment;
  localparam int StageDepth = SegmentIdPacket * PixCols;
  localparam int ImgDepth   = ImgRows * PixCols;
  localparam int SegWords   = PacketsPerSegment * PixCols;

  localparam int StageAw = $clog2(StageDepth);
  localparam int ImgAw   = $clog2(ImgDepth);
  localparam int CopyCw  = $clog2(StageDepth + 1);

  localparam logic [1:0] CmdStream = 2'd0;
  localparam logic [1:0] CmdStart  = 2'd1;
  localparam logic [1:0] CmdRead   = 2'd2;

  typedef enum logic [2:0] {
    OP_ID,
    OP_BODY,
    OP_START,
    OP_READ,
    OP_NOP
  } op_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STAGING,
    MODE_LOCKED
  } lock_mode_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_COPY
  } back_state_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [15:0] word;
    logic [ImgAw-1:0] rd_addr;
    logic        rd_ok;
  } op_t;

endpackage

/* src/vsr_if.sv */
// ---------------------------------------------------------------------------
// Reassembler channel interfaces
// Input request channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface vsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] link_word;
  logic        packet_start;
  logic [7:0]  read_row;
  logic [6:0]  read_col;

  modport source (output valid, cmd, link_word, packet_start, read_row, read_col,
                  input ready);
  modport sink   (input valid, cmd, link_word, packet_start, read_row, read_col,
                  output ready);
endinterface

interface vsr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  segment_status;
  logic [15:0] pixel_value;
  logic        locked;
  logic        staging;

  modport source (output valid, segment_status, pixel_value, locked, staging,
                  input ready);
  modport sink   (input valid, segment_status, pixel_value, locked, staging,
                  output ready);
endinterface

/* src/vsr_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module vsr_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* src/vsr_front.sv */
// ---------------------------------------------------------------------------
// Reassembler front end
// Accepts requests, decodes them into operations and queues up to two of them.
// ---------------------------------------------------------------------------
module vsr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  vsr_in_if.sink        in_i,
  output vsr_pkg::op_t  op_o,
  output logic          op_valid_o,
  input  logic          op_ready_i
);
  import vsr_pkg::*;

  op_t        slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  op_t        dec;
  logic       push, pop;
  logic [ImgAw-1:0] row_base;

  assign row_base = ImgAw'(in_i.read_row) * ImgAw'(PixCols);

  always_comb begin
    dec.word    = in_i.link_word;
    dec.rd_addr = row_base + ImgAw'(in_i.read_col);
    dec.rd_ok   = (32'(in_i.read_row) < ImgRows) && (32'(in_i.read_col) < PixCols);
    case (in_i.cmd)
      CmdStream: dec.kind = in_i.packet_start ? OP_ID : OP_BODY;
      CmdStart:  dec.kind = OP_START;
      CmdRead:   dec.kind = OP_READ;
      default:   dec.kind = OP_NOP;
    endcase
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign op_valid_o = (cnt_q != 2'd0);
  assign pop        = op_valid_o && op_ready_i;
  assign op_o       = slot_q[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= dec;
    end
  end
endmodule

/* src/vsr_back.sv */
// ---------------------------------------------------------------------------
// Reassembler back end
// Executes operations: packet tracking, stage and image stores, commit copy, pixel reads.
// ---------------------------------------------------------------------------
`include "vospi_segment_reassembler_assert.svh"

module vsr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vsr_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  vsr_out_if.source     out_o
);
  import vsr_pkg::*;

  back_state_e state_q, state_d;
  lock_mode_e  mode_q, mode_d;
  logic [6:0]  wpos_q, wpos_d;
  logic [7:0]  cp_q, cp_d;
  logic        acc_q, acc_d;
  logic [2:0]  seg_q, seg_d;
  logic [4:0]  stg_q, stg_d;
  logic [3:0]  stat_q, stat_d;
  logic [ImgAw-1:0] addr_q, addr_d;
  logic [ImgAw-1:0] sbase_q, sbase_d;
  logic [CopyCw-1:0] ccnt_q, ccnt_d;
  logic        rd_ok_q, rd_ok_d;

  logic        ov_q, ov_d;
  logic [3:0]  o_stat_q, o_stat_d;
  logic [15:0] o_pix_q, o_pix_d;
  logic        o_lock_q, o_lock_d;
  logic        o_stg_q, o_stg_d;

  logic        out_free, take;
  logic [7:0]  hi, pn;
  logic [2:0]  nseg;
  logic [7:0]  pos;
  logic [ImgAw-1:0] pn_base, nseg_base;
  logic        commit;

  logic             st_we, st_re, im_we, im_re;
  logic [StageAw-1:0] st_waddr, st_raddr;
  logic [ImgAw-1:0] im_waddr, im_raddr;
  logic [15:0]      st_wdata, st_rdata, im_wdata, im_rdata;

  assign out_free   = !ov_q || out_o.ready;
  assign op_ready_o = (state_q == ST_RUN) && out_free;
  assign take       = op_valid_i && op_ready_o;

  assign hi        = op_i.word[15:8];
  assign pn        = op_i.word[7:0];
  assign nseg      = hi[6:4];
  assign pos       = {1'b0, wpos_q} + 8'd1;
  assign pn_base   = ImgAw'(pn) * ImgAw'(PixCols);
  assign nseg_base = ImgAw'(nseg - 3'd1) * ImgAw'(SegWords);

  always_comb begin
    mode_d  = mode_q;
    wpos_d  = wpos_q;
    cp_d    = cp_q;
    acc_d   = acc_q;
    seg_d   = seg_q;
    stg_d   = stg_q;
    stat_d  = stat_q;
    addr_d  = addr_q;
    sbase_d = sbase_q;
    rd_ok_d = rd_ok_q;
    commit  = 1'b0;
    st_we   = 1'b0;
    im_we   = 1'b0;
    st_waddr = addr_q[StageAw-1:0];
    st_wdata = op_i.word;
    im_waddr = addr_q;
    im_wdata = op_i.word;
    im_re    = 1'b0;
    im_raddr = op_i.rd_addr;
    st_re    = 1'b0;
    st_raddr = ccnt_q[StageAw-1:0];
    ccnt_d   = ccnt_q;

    if (take) begin
      case (op_i.kind)
        OP_ID: begin
          wpos_d = 7'd0;
          acc_d  = 1'b0;
          if (hi[3:0] == 4'hF) begin
            mode_d = MODE_IDLE;
            stg_d  = 5'd0;
          end else if (32'(pn) >= PacketsPerSegment) begin
            mode_d = mode_q;
          end else if (pn == 8'd0) begin
            mode_d = MODE_STAGING;
            stg_d  = 5'd1;
            cp_d   = 8'd0;
            acc_d  = 1'b1;
            addr_d = '0;
          end else if (mode_q == MODE_LOCKED) begin
            cp_d   = pn;
            acc_d  = 1'b1;
            addr_d = sbase_q + pn_base;
          end else if (mode_q != MODE_STAGING || pn != {3'd0, stg_q}) begin
            mode_d = MODE_IDLE;
            stg_d  = 5'd0;
          end else if (32'(pn) < SegmentIdPacket) begin
            cp_d   = pn;
            stg_d  = pn[4:0] + 5'd1;
            acc_d  = 1'b1;
            addr_d = pn_base;
          end else if (nseg < 3'd1 || 32'(nseg) > SegmentCount) begin
            mode_d = MODE_IDLE;
            stg_d  = 5'd0;
          end else begin
            commit  = 1'b1;
            mode_d  = MODE_LOCKED;
            seg_d   = nseg;
            stg_d   = 5'd0;
            cp_d    = pn;
            acc_d   = 1'b1;
            sbase_d = nseg_base;
            addr_d  = nseg_base + pn_base;
            ccnt_d  = '0;
          end
        end
        OP_BODY: begin
          if (acc_q && 32'(pos) < WordsPerPacket) begin
            wpos_d = pos[6:0];
            if (pos >= 8'd2) begin
              if (mode_q == MODE_STAGING && 32'(cp_q) < SegmentIdPacket) begin
                st_we  = 1'b1;
                addr_d = addr_q + ImgAw'(1);
              end else if (mode_q == MODE_LOCKED) begin
                im_we  = 1'b1;
                addr_d = addr_q + ImgAw'(1);
              end
            end
            if (32'(pos) == WordsPerPacket - 1) begin
              acc_d = 1'b0;
              if (mode_q == MODE_LOCKED && 32'(cp_q) == PacketsPerSegment - 1 &&
                  seg_q >= 3'd1 && 32'(seg_q) <= SegmentCount) begin
                stat_d = stat_q | 4'(1 << (seg_q - 3'd1));
              end
            end
          end
        end
        OP_START: begin
          stat_d = 4'd0;
          mode_d = MODE_IDLE;
          stg_d  = 5'd0;
          acc_d  = 1'b0;
          wpos_d = 7'd0;
        end
        OP_READ: begin
          im_re   = 1'b1;
          rd_ok_d = op_i.rd_ok;
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end

    if (state_q == ST_COPY) begin
      st_re  = (32'(ccnt_q) < StageDepth);
      ccnt_d = ccnt_q + CopyCw'(1);
      if (ccnt_q != '0) begin
        im_we    = 1'b1;
        im_waddr = sbase_q + ImgAw'(ccnt_q - CopyCw'(1));
        im_wdata = st_rdata;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (take && op_i.kind == OP_READ) begin
          state_d = ST_READ;
        end else if (take && commit) begin
          state_d = ST_COPY;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_d = ST_RUN;
        end
      end
      ST_COPY: begin
        if (32'(ccnt_q) == StageDepth) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    ov_d     = ov_q && !out_o.ready;
    o_stat_d = o_stat_q;
    o_pix_d  = o_pix_q;
    o_lock_d = o_lock_q;
    o_stg_d  = o_stg_q;
    if (take && op_i.kind != OP_READ) begin
      ov_d     = 1'b1;
      o_stat_d = stat_d;
      o_pix_d  = 16'd0;
      o_lock_d = (mode_d == MODE_LOCKED);
      o_stg_d  = (mode_d == MODE_STAGING);
    end else if (state_q == ST_READ && out_free) begin
      ov_d     = 1'b1;
      o_stat_d = stat_q;
      o_pix_d  = rd_ok_q ? im_rdata : 16'd0;
      o_lock_d = (mode_q == MODE_LOCKED);
      o_stg_d  = (mode_q == MODE_STAGING);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      mode_q  <= MODE_IDLE;
      wpos_q  <= 7'd0;
      cp_q    <= 8'd0;
      acc_q   <= 1'b0;
      seg_q   <= 3'd0;
      stg_q   <= 5'd0;
      stat_q  <= 4'd0;
      ccnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      wpos_q  <= wpos_d;
      cp_q    <= cp_d;
      acc_q   <= acc_d;
      seg_q   <= seg_d;
      stg_q   <= stg_d;
      stat_q  <= stat_d;
      ccnt_q  <= ccnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    sbase_q  <= sbase_d;
    rd_ok_q  <= rd_ok_d;
    o_stat_q <= o_stat_d;
    o_pix_q  <= o_pix_d;
    o_lock_q <= o_lock_d;
    o_stg_q  <= o_stg_d;
  end

  vsr_ram #(.Width(16), .Depth(StageDepth)) u_stage (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  vsr_ram #(.Width(16), .Depth(ImgDepth)) u_image (
    .clk_i   (clk_i),
    .we_i    (im_we),
    .waddr_i (im_waddr),
    .wdata_i (im_wdata),
    .re_i    (im_re),
    .raddr_i (im_raddr),
    .rdata_o (im_rdata)
  );

  assign out_o.valid          = ov_q;
  assign out_o.segment_status = o_stat_q;
  assign out_o.pixel_value    = o_pix_q;
  assign out_o.locked         = o_lock_q;
  assign out_o.staging        = o_stg_q;

  `VSR_ASSERT_NOW(a_copy_locked, state_q == ST_COPY, mode_q == MODE_LOCKED)
  `VSR_ASSERT_NOW(a_copy_bound, state_q == ST_COPY, 32'(ccnt_q) <= StageDepth)
  `VSR_ASSERT_NEXT(a_out_hold, ov_q && !out_o.ready, ov_q && $stable(o_pix_q))
endmodule

/* src/vospi_segment_reassembler.sv */
// A result is registered as the back end takes its request; a pixel read registers image
// store read data first. One request per cycle through a two-entry request queue unless
// the result channel stalls; a pixel read holds the back end until its result is
// registered. A valid segment ID packet starts a copy of the stage store into the image
// store over the single image write port; no request executes meanwhile. Reset (rst_ni
// low, asynchronous) idles the lock, clears status and empties the queue.
// ---------------------------------------------------------------------------
// Segment reassembler top level
// Front decoder and queue feeding the executing back end.
// ---------------------------------------------------------------------------
module vospi_segment_reassembler (
  input  logic      clk_i,
  input  logic      rst_ni,
  vsr_in_if.sink    in_i,
  vsr_out_if.source out_o
);
  import vsr_pkg::*;

  op_t  op;
  logic op_valid, op_ready;

  vsr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .op_o       (op),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready)
  );

  vsr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_ready_o (op_ready),
    .out_o      (out_o)
  );
endmodule
